@@ src/one_wire_uart_master_engine_defines.svh @@
// Assertion macros shared by the 1-Wire over UART master engine modules.
`ifndef ONE_WIRE_UART_MASTER_ENGINE_DEFINES_SVH
`define ONE_WIRE_UART_MASTER_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OWUM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OWUM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/owum_pkg.sv @@
// Types, constants and helper functions of the 1-Wire over UART master engine.
package owum_pkg;

   localparam int QUEUE_DEPTH = 24;
   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QSUM_W = QCNT_W + 1;
   localparam int COUNT_CMP_W = 9;
   localparam int HPOS_W = 4;
   localparam int HDR_MATCH_LEN = 9;
   localparam int HDR_SKIP_LEN = 1;

   localparam logic [7:0] RESET_WORD = 8'hF0;
   localparam logic [7:0] ONE_WORD = 8'hFF;
   localparam logic [7:0] ZERO_WORD = 8'h00;
   localparam logic [7:0] MATCH_ROM_CMD = 8'h55;
   localparam logic [7:0] SKIP_ROM_CMD = 8'hCC;

   typedef enum logic [2:0] {
      OP_CLEAR = 3'd0,
      OP_PUSH  = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_ECHO  = 3'd4,
      OP_READY = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RESET,
      PH_RECEIVE,
      PH_TRANSMIT,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_BUSY  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      QC_NONE,
      QC_CLEAR,
      QC_PUSH,
      QC_WRITE,
      QC_READ,
      QC_POP
   } queue_op_type;

   typedef enum logic [1:0] {
      WK_NONE,
      WK_RESET,
      WK_BYTE
   } word_kind_type;

   typedef struct packed {
      queue_op_type       code;
      logic [7:0]         data;
      logic [QCNT_W-1:0]  read_fill;
      logic [63:0]        rom_address;
   } queue_cmd_type;

   typedef struct packed {
      logic [QCNT_W-1:0]  fill;
      logic [7:0]         head_byte;
      logic [QCNT_W-1:0]  write_len;
   } queue_stat_type;

   // Byte at a given position of the addressing header.
   function automatic logic [7:0] header_byte(input logic [63:0] rom,
                                              input logic [HPOS_W-1:0] pos);
      logic [7:0] b;
      if (rom == 64'd0) begin
         b = SKIP_ROM_CMD;
      end else begin
         case (pos)
            4'd1: b = rom[7:0];
            4'd2: b = rom[15:8];
            4'd3: b = rom[23:16];
            4'd4: b = rom[31:24];
            4'd5: b = rom[39:32];
            4'd6: b = rom[47:40];
            4'd7: b = rom[55:48];
            4'd8: b = rom[63:56];
            default: b = MATCH_ROM_CMD;
         endcase
      end
      return b;
   endfunction

endpackage

@@ src/owum_queue.sv @@
// Circular byte queue with clear, header prepend, read-slot fill, push and pop.
`include "one_wire_uart_master_engine_defines.svh"

module owum_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  owum_pkg::queue_cmd_type cmd,
   output owum_pkg::queue_stat_type stat
);
   import owum_pkg::*;

   logic [7:0]        entry_ff [QUEUE_DEPTH];
   logic [7:0]        entry_in [QUEUE_DEPTH];
   logic [QIDX_W-1:0] head_ff, head_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;

   logic [QCNT_W-1:0] hdr_len;
   logic [QCNT_W-1:0] keep_max;
   logic [QCNT_W-1:0] kept;
   logic [QCNT_W-1:0] write_len;
   logic [QSUM_W-1:0] wr_head_sum;
   logic [QIDX_W-1:0] wr_head;
   logic [QSUM_W-1:0] tail_sum;
   logic [QIDX_W-1:0] tail;
   logic [QIDX_W-1:0] head_next;

   always_comb begin
      hdr_len = (cmd.rom_address != 64'd0) ? QCNT_W'(HDR_MATCH_LEN) : QCNT_W'(HDR_SKIP_LEN);
      keep_max = QCNT_W'(QUEUE_DEPTH) - hdr_len;
      kept = (fill_ff > keep_max) ? keep_max : fill_ff;
      write_len = hdr_len + kept;

      wr_head_sum = QSUM_W'(head_ff) + QSUM_W'(QUEUE_DEPTH) - QSUM_W'(hdr_len);
      if (wr_head_sum >= QSUM_W'(QUEUE_DEPTH)) begin
         wr_head_sum = wr_head_sum - QSUM_W'(QUEUE_DEPTH);
      end
      wr_head = wr_head_sum[QIDX_W-1:0];

      tail_sum = QSUM_W'(head_ff) + QSUM_W'(fill_ff);
      if (tail_sum >= QSUM_W'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - QSUM_W'(QUEUE_DEPTH);
      end
      tail = tail_sum[QIDX_W-1:0];

      head_next = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   end

   always_comb begin
      logic [QSUM_W-1:0] off;
      head_in = head_ff;
      fill_in = fill_ff;
      off = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
      end
      case (cmd.code)
         QC_CLEAR: begin
            head_in = '0;
            fill_in = '0;
         end
         QC_PUSH: begin
            entry_in[tail] = cmd.data;
            fill_in = fill_ff + 1'b1;
         end
         QC_WRITE: begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               off = QSUM_W'(i) + QSUM_W'(QUEUE_DEPTH) - QSUM_W'(wr_head);
               if (off >= QSUM_W'(QUEUE_DEPTH)) begin
                  off = off - QSUM_W'(QUEUE_DEPTH);
               end
               if (off < QSUM_W'(hdr_len)) begin
                  entry_in[i] = header_byte(cmd.rom_address, off[HPOS_W-1:0]);
               end
            end
            head_in = wr_head;
            fill_in = write_len;
         end
         QC_READ: begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               entry_in[i] = ONE_WORD;
            end
            head_in = '0;
            fill_in = cmd.read_fill;
         end
         QC_POP: begin
            head_in = head_next;
            fill_in = fill_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   assign stat.fill = fill_ff;
   assign stat.head_byte = entry_ff[head_ff];
   assign stat.write_len = write_len;

   `OWUM_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= QCNT_W'(QUEUE_DEPTH),
                    "Queue fill exceeds its depth.")
   `OWUM_ASSERT_NOW(a_pop_nonempty, cmd.code == QC_POP, fill_ff != '0,
                    "Pop from an empty queue.")
   `OWUM_ASSERT_NOW(a_push_room, cmd.code == QC_PUSH, fill_ff < QCNT_W'(QUEUE_DEPTH),
                    "Push into a full queue.")

endmodule

@@ src/one_wire_uart_master_engine.sv @@
// 1-Wire master engine over a UART in loopback: command decode, sequencing and word output.
// Each transaction on the request channel is latched into an input register, decoded into the
// engine state and the byte queue, and handed to a result register that sends one UART word per
// response transaction: an accepted start-read command or a transmitter-ready command that pops
// a byte occupies the response channel for one transaction per bit, every other command for a
// single transaction, and the receiver may stall any of them. The input register takes the next
// command while the result register still drains, so commands follow each other with no gap
// beyond the response words; a request passes the input register, then the result register.
`include "one_wire_uart_master_engine_defines.svh"

module one_wire_uart_master_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_word,
   output logic        rsp_rate_select,
   output logic        rsp_rx_valid,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_accepted,
   output logic        rsp_done_event,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);
   import owum_pkg::*;

   logic [63:0]       rom_address_ff, rom_address_in;

   logic              in_valid_ff, in_valid_in;
   logic [2:0]        in_opcode_ff, in_opcode_in;
   logic [7:0]        in_data_ff, in_data_in;
   logic [7:0]        in_count_ff, in_count_in;

   phase_type         phase_ff, phase_in;
   logic [2:0]        bit_idx_ff, bit_idx_in;
   logic [7:0]        asm_ff, asm_in;
   logic [QCNT_W-1:0] remain_ff, remain_in;
   logic              data_rate_ff, data_rate_in;

   logic              out_valid_ff, out_valid_in;
   word_kind_type     kind_ff, kind_in;
   logic [7:0]        byte_ff, byte_in;
   logic [2:0]        idx_ff, idx_in;
   logic              rate_ff, rate_in;
   logic              rxv_ff, rxv_in;
   logic [7:0]        rxb_ff, rxb_in;
   logic              acc_ff, acc_in;
   logic              done_ff, done_in;
   status_type        status_ff, status_in;

   queue_cmd_type     qcmd;
   queue_stat_type    qstat;

   logic              out_last;
   logic              out_take;
   logic              out_done;
   logic              move;
   logic [QCNT_W-1:0] read_n;
   logic [7:0]        asm_bit;

   owum_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (qcmd),
      .stat  (qstat)
   );

   assign out_last = (kind_ff != WK_BYTE) || (idx_ff == 3'd7);
   assign out_take = out_valid_ff && !rsp_stall;
   assign out_done = out_take && out_last;
   assign move = in_valid_ff && (!out_valid_ff || out_done);
   assign req_stall = in_valid_ff && !move;

   assign rom_address_in = csr_wr_en ? csr_wr_data : rom_address_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_opcode_in = in_opcode_ff;
      in_data_in = in_data_ff;
      in_count_in = in_count_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_opcode_in = req_opcode;
         in_data_in = req_data_byte;
         in_count_in = req_byte_count;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      read_n = (COUNT_CMP_W'(in_count_ff) > COUNT_CMP_W'(QUEUE_DEPTH)) ?
               QCNT_W'(QUEUE_DEPTH) : QCNT_W'(in_count_ff);
      asm_bit = '0;
      asm_bit[bit_idx_ff] = (phase_ff == PH_RECEIVE) && in_data_ff[0];
   end

   always_comb begin
      phase_in = phase_ff;
      bit_idx_in = bit_idx_ff;
      asm_in = asm_ff;
      remain_in = remain_ff;
      data_rate_in = data_rate_ff;

      qcmd.code = QC_NONE;
      qcmd.data = in_data_ff;
      qcmd.read_fill = read_n - 1'b1;
      qcmd.rom_address = rom_address_ff;

      kind_in = kind_ff;
      byte_in = byte_ff;
      rxv_in = rxv_ff;
      rxb_in = rxb_ff;
      acc_in = acc_ff;
      done_in = done_ff;
      status_in = status_ff;
      rate_in = rate_ff;

      if (move) begin
         kind_in = WK_NONE;
         byte_in = ZERO_WORD;
         rxv_in = 1'b0;
         rxb_in = '0;
         acc_in = 1'b0;
         done_in = 1'b0;
         case (in_opcode_ff)
            OP_CLEAR: begin
               qcmd.code = QC_CLEAR;
               acc_in = 1'b1;
            end
            OP_PUSH: begin
               if (qstat.fill < QCNT_W'(QUEUE_DEPTH)) begin
                  qcmd.code = QC_PUSH;
                  acc_in = 1'b1;
               end
            end
            OP_WRITE: begin
               if (qstat.fill != '0) begin
                  qcmd.code = QC_WRITE;
                  remain_in = qstat.write_len;
                  bit_idx_in = '0;
                  data_rate_in = 1'b0;
                  phase_in = PH_RESET;
                  kind_in = WK_RESET;
                  acc_in = 1'b1;
               end
            end
            OP_READ: begin
               if (in_count_ff != 8'd0) begin
                  qcmd.code = QC_READ;
                  remain_in = read_n;
                  bit_idx_in = '0;
                  asm_in = '0;
                  phase_in = PH_RECEIVE;
                  kind_in = WK_BYTE;
                  byte_in = ONE_WORD;
                  acc_in = 1'b1;
               end
            end
            OP_ECHO: begin
               if (phase_ff == PH_RESET) begin
                  acc_in = 1'b1;
                  if (in_data_ff != RESET_WORD) begin
                     data_rate_in = 1'b1;
                     phase_in = PH_TRANSMIT;
                  end else begin
                     phase_in = PH_ERROR;
                     done_in = 1'b1;
                  end
               end else if (phase_ff == PH_RECEIVE || phase_ff == PH_TRANSMIT) begin
                  acc_in = 1'b1;
                  asm_in = asm_ff | asm_bit;
                  bit_idx_in = bit_idx_ff + 1'b1;
                  if (bit_idx_ff == 3'd7) begin
                     if (phase_ff == PH_RECEIVE) begin
                        rxv_in = 1'b1;
                        rxb_in = asm_ff | asm_bit;
                        asm_in = '0;
                     end
                     remain_in = (remain_ff != '0) ? remain_ff - 1'b1 : remain_ff;
                     if (remain_ff <= QCNT_W'(1)) begin
                        phase_in = PH_IDLE;
                        done_in = 1'b1;
                     end
                  end
               end
            end
            OP_READY: begin
               if ((phase_ff == PH_RECEIVE || phase_ff == PH_TRANSMIT) &&
                   qstat.fill != '0) begin
                  qcmd.code = QC_POP;
                  kind_in = WK_BYTE;
                  byte_in = qstat.head_byte;
                  acc_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         rate_in = data_rate_in;
         case (phase_in)
            PH_IDLE:  status_in = ST_IDLE;
            PH_ERROR: status_in = ST_ERROR;
            default:  status_in = ST_BUSY;
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      idx_in = idx_ff;
      if (move) begin
         out_valid_in = 1'b1;
         idx_in = '0;
      end else if (out_done) begin
         out_valid_in = 1'b0;
         idx_in = '0;
      end else if (out_take) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      in_opcode_ff <= in_opcode_in;
      in_data_ff <= in_data_in;
      in_count_ff <= in_count_in;
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      rate_ff <= rate_in;
      rxv_ff <= rxv_in;
      rxb_ff <= rxb_in;
      acc_ff <= acc_in;
      done_ff <= done_in;
      status_ff <= status_in;
      if (reset) begin
         rom_address_ff <= '0;
         in_valid_ff <= 1'b0;
         phase_ff <= PH_IDLE;
         bit_idx_ff <= '0;
         asm_ff <= '0;
         remain_ff <= '0;
         data_rate_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         rom_address_ff <= rom_address_in;
         in_valid_ff <= in_valid_in;
         phase_ff <= phase_in;
         bit_idx_ff <= bit_idx_in;
         asm_ff <= asm_in;
         remain_ff <= remain_in;
         data_rate_ff <= data_rate_in;
         out_valid_ff <= out_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      case (kind_ff)
         WK_RESET: rsp_tx_word = RESET_WORD;
         WK_BYTE:  rsp_tx_word = byte_ff[idx_ff] ? ONE_WORD : ZERO_WORD;
         default:  rsp_tx_word = ZERO_WORD;
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_tx_valid = (kind_ff != WK_NONE);
   assign rsp_rate_select = rate_ff;
   assign rsp_rx_valid = rxv_ff;
   assign rsp_rx_byte = rxb_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_done_event = done_ff;
   assign rsp_status = status_ff;
   assign rsp_last = out_last;

   `OWUM_ASSERT_NOW(a_stall_blocked, in_valid_ff && out_valid_ff && !out_done, req_stall,
                    "Request not stalled while the result register drains.")
   `OWUM_ASSERT_NOW(a_idx_in_byte, idx_ff != 3'd0, out_valid_ff && kind_ff == WK_BYTE,
                    "Word index runs outside an expanded byte.")
   `OWUM_ASSERT_NEXT(a_presence_rate,
                     move && phase_ff == PH_RESET && in_opcode_ff == OP_ECHO &&
                     in_data_ff != RESET_WORD,
                     data_rate_ff && phase_ff == PH_TRANSMIT,
                     "Presence echo did not switch to the data rate.")

endmodule
